@@ hdl/coalescing_write_command_queue_defines.svh @@
// Assertion macros shared by the coalescing write command queue
`ifndef COALESCING_WRITE_COMMAND_QUEUE_DEFINES_SVH
`define COALESCING_WRITE_COMMAND_QUEUE_DEFINES_SVH

// Condition that holds on every clock edge out of reset
`define CWQ_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence in the same cycle
`define CWQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequence in the next cycle
`define CWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/cwq_pkg.sv @@
// Shared types and codes of the coalescing write command queue
package cwq_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [2:0] ST_APPENDED = 3'd0;
  localparam logic [2:0] ST_MERGED   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_BADCOUNT = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_POPPED   = 3'd5;

  typedef struct packed {
    logic        opcode;
    logic [15:0] reg_address;
    logic [7:0]  word_count;
    logic [1:0]  write_mode;
    logic [15:0] data_word;
    logic        word_last;
    logic        merge_ok;
  } cwq_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_address;
    logic [7:0]  out_count;
    logic [1:0]  out_mode;
    logic [15:0] out_word;
    logic        out_last;
    logic [4:0]  occupancy;
  } cwq_out_t;

endpackage

@@ hdl/cwq_ram.sv @@
// Generic single write port, single read port RAM with registered read
module cwq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/cwq_obuf.sv @@
// Output register stage of the result channel
module cwq_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ld,
  input  cwq_pkg::cwq_out_t ld_data,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output cwq_pkg::cwq_out_t out_data
);
  import cwq_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  cwq_out_t data_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (ld) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      data_r <= ld_data;
    end
  end

endmodule

@@ hdl/coalescing_write_command_queue.sv @@
// Coalescing write command queue: header RAM, word RAM and sequencer, one item at a time.
// Push beat: accepted, then written in the update state; the final beat of a run also loads the result.
// A merge search reads the queued headers one by one from the head before the update; a match merges there.
// Pop: accept, then one result per cycle while the output register is free, word_count results; empty pop gives one.
// Results leave through an output register, so the next item is taken while one waits.
// Reset clears pointers, counts, sequencer and output valid only; RAM contents stay undefined until written.
`include "coalescing_write_command_queue_defines.svh"
module coalescing_write_command_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_WORDS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cwq_pkg::cwq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cwq_pkg::cwq_out_t out_data
);
  import cwq_pkg::*;

  localparam int QIW    = $clog2(QUEUE_DEPTH);
  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int CW     = $clog2(MAX_WORDS + 1);
  localparam int WDEPTH = QUEUE_DEPTH * MAX_WORDS;
  localparam int WAW    = $clog2(WDEPTH);
  // header entry: address, word count, mode, words actually supplied
  localparam int HW     = 16 + CW + 2 + CW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MSCAN  = 3'd1;
  localparam logic [2:0] S_PUSH   = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_POP_LD = 3'd4;

  function automatic logic [QIW-1:0] slot_inc(input logic [QIW-1:0] s);
    return (s == QIW'(QUEUE_DEPTH - 1)) ? '0 : s + QIW'(1);
  endfunction

  function automatic logic [WAW-1:0] word_addr(input logic [QIW-1:0] s,
                                               input logic [CW-1:0]  k);
    return WAW'(s) * WAW'(MAX_WORDS) + WAW'(k);
  endfunction

  // control registers
  logic [2:0]     state_r, state_nxt;
  logic [QIW-1:0] head_r, head_nxt;
  logic [QIW-1:0] tail_r, tail_nxt;
  logic [QCW-1:0] qcount_r, qcount_nxt;
  logic [CW-1:0]  run_idx_r, run_idx_nxt;

  // payload registers
  cwq_in_t        item_r, item_nxt;
  logic [2:0]     run_st_r, run_st_nxt;
  logic [15:0]    run_addr_r, run_addr_nxt;
  logic [CW-1:0]  run_cnt_r, run_cnt_nxt;
  logic [1:0]     run_mode_r, run_mode_nxt;
  logic [QIW-1:0] scan_idx_r, scan_idx_nxt;
  logic [QCW-1:0] scan_n_r, scan_n_nxt;
  logic [QIW-1:0] pop_slot_r, pop_slot_nxt;
  logic [CW-1:0]  pop_k_r, pop_k_nxt;
  logic [2:0]     res_st_r, res_st_nxt;

  // RAM ports
  logic           hdr_we, hdr_re;
  logic [QIW-1:0] hdr_waddr, hdr_raddr;
  logic [HW-1:0]  hdr_wdata, hdr_rdata;
  logic           wrd_we, wrd_re;
  logic [WAW-1:0] wrd_waddr, wrd_raddr;
  logic [15:0]    wrd_wdata, wrd_rdata;

  logic [15:0]    hdr_addr;
  logic [CW-1:0]  hdr_cnt;
  logic [1:0]     hdr_mode;
  logic [CW-1:0]  hdr_fill;

  // output stage
  logic           ob_ld, ob_free;
  cwq_out_t       ob_data;

  // working values
  logic           accept;
  logic           first;
  logic           bad_cnt;
  logic           is_full;
  logic           match;
  logic           pop_last;
  logic [2:0]     push_st;
  logic [CW-1:0]  cnt_eff;
  logic [15:0]    addr_eff;
  logic [1:0]     mode_eff;
  logic [CW-1:0]  idx_inc;
  logic [CW-1:0]  fill;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign hdr_addr = hdr_rdata[HW-1 -: 16];
  assign hdr_cnt  = hdr_rdata[HW-17 -: CW];
  assign hdr_mode = hdr_rdata[CW+1 -: 2];
  assign hdr_fill = hdr_rdata[CW-1:0];

  cwq_ram #(.WIDTH(HW), .DEPTH(QUEUE_DEPTH)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (hdr_waddr),
    .wdata (hdr_wdata),
    .re    (hdr_re),
    .raddr (hdr_raddr),
    .rdata (hdr_rdata)
  );

  cwq_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_wrd_ram (
    .clk   (clk),
    .we    (wrd_we),
    .waddr (wrd_waddr),
    .wdata (wrd_wdata),
    .re    (wrd_re),
    .raddr (wrd_raddr),
    .rdata (wrd_rdata)
  );

  cwq_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ob_ld),
    .ld_data   (ob_data),
    .free      (ob_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // push decision terms, taken from the held item, run registers and queue count
  assign first    = (run_idx_r == '0);
  assign bad_cnt  = (item_r.word_count == 8'd0) || (item_r.word_count > 8'(MAX_WORDS));
  assign is_full  = (qcount_r == QCW'(QUEUE_DEPTH));
  assign push_st  = !first ? run_st_r :
                    bad_cnt ? ST_BADCOUNT :
                    is_full ? ST_FULL : ST_APPENDED;
  assign cnt_eff  = first ? CW'(item_r.word_count) : run_cnt_r;
  assign addr_eff = first ? item_r.reg_address : run_addr_r;
  assign mode_eff = first ? item_r.write_mode : run_mode_r;
  assign idx_inc  = (run_idx_r < CW'(MAX_WORDS)) ? run_idx_r + CW'(1) : run_idx_r;
  assign fill     = (idx_inc < cnt_eff) ? idx_inc : cnt_eff;

  assign match    = (hdr_addr == item_r.reg_address) && (hdr_cnt == CW'(1));
  assign pop_last = ((pop_k_r + CW'(1)) >= hdr_cnt);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    qcount_nxt   = qcount_r;
    run_idx_nxt  = run_idx_r;
    item_nxt     = item_r;
    run_st_nxt   = run_st_r;
    run_addr_nxt = run_addr_r;
    run_cnt_nxt  = run_cnt_r;
    run_mode_nxt = run_mode_r;
    scan_idx_nxt = scan_idx_r;
    scan_n_nxt   = scan_n_r;
    pop_slot_nxt = pop_slot_r;
    pop_k_nxt    = pop_k_r;
    res_st_nxt   = res_st_r;

    hdr_we    = 1'b0;
    hdr_waddr = '0;
    hdr_wdata = '0;
    hdr_re    = 1'b0;
    hdr_raddr = '0;
    wrd_we    = 1'b0;
    wrd_waddr = '0;
    wrd_wdata = '0;
    wrd_re    = 1'b0;
    wrd_raddr = '0;

    ob_ld   = 1'b0;
    ob_data = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          if (in_data.opcode == OP_POP) begin
            if (qcount_r == '0) begin
              res_st_nxt = ST_EMPTY;
              state_nxt  = S_EMIT;
            end else begin
              // header and first word fetched together
              hdr_re       = 1'b1;
              hdr_raddr    = head_r;
              wrd_re       = 1'b1;
              wrd_raddr    = word_addr(head_r, '0);
              pop_slot_nxt = head_r;
              pop_k_nxt    = '0;
              head_nxt     = slot_inc(head_r);
              qcount_nxt   = qcount_r - QCW'(1);
              state_nxt    = S_POP_LD;
            end
          end else if (first && in_data.word_count == 8'd1 && in_data.merge_ok &&
                       qcount_r != '0) begin
            hdr_re       = 1'b1;
            hdr_raddr    = head_r;
            scan_idx_nxt = head_r;
            scan_n_nxt   = '0;
            state_nxt    = S_MSCAN;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end

      S_MSCAN: begin
        // hdr_rdata belongs to scan_idx_r
        if (match) begin
          hdr_we      = 1'b1;
          hdr_waddr   = scan_idx_r;
          hdr_wdata   = {hdr_addr, hdr_cnt, item_r.write_mode, CW'(1)};
          wrd_we      = 1'b1;
          wrd_waddr   = word_addr(scan_idx_r, '0);
          wrd_wdata   = item_r.data_word;
          run_st_nxt  = ST_MERGED;
          if (item_r.word_last) begin
            res_st_nxt  = ST_MERGED;
            run_idx_nxt = '0;
            state_nxt   = S_EMIT;
          end else begin
            run_idx_nxt = CW'(1);
            state_nxt   = S_IDLE;
          end
        end else if ((scan_n_r + QCW'(1)) == qcount_r) begin
          state_nxt = S_PUSH;
        end else begin
          hdr_re       = 1'b1;
          hdr_raddr    = slot_inc(scan_idx_r);
          scan_idx_nxt = slot_inc(scan_idx_r);
          scan_n_nxt   = scan_n_r + QCW'(1);
        end
      end

      S_PUSH: begin
        if (first) begin
          run_st_nxt   = push_st;
          run_addr_nxt = addr_eff;
          run_cnt_nxt  = cnt_eff;
          run_mode_nxt = mode_eff;
        end
        if (push_st == ST_APPENDED && run_idx_r < cnt_eff) begin
          wrd_we    = 1'b1;
          wrd_waddr = word_addr(tail_r, run_idx_r);
          wrd_wdata = item_r.data_word;
        end
        if (item_r.word_last) begin
          if (push_st == ST_APPENDED) begin
            // words never supplied read back as zero through the fill mark
            hdr_we     = 1'b1;
            hdr_waddr  = tail_r;
            hdr_wdata  = {addr_eff, cnt_eff, mode_eff, fill};
            tail_nxt   = slot_inc(tail_r);
            qcount_nxt = qcount_r + QCW'(1);
          end
          res_st_nxt  = push_st;
          run_idx_nxt = '0;
          state_nxt   = S_EMIT;
        end else begin
          run_idx_nxt = idx_inc;
          state_nxt   = S_IDLE;
        end
      end

      S_EMIT: begin
        if (ob_free) begin
          ob_ld             = 1'b1;
          ob_data.status    = res_st_r;
          ob_data.out_last  = 1'b1;
          ob_data.occupancy = 5'(qcount_r);
          state_nxt         = S_IDLE;
        end
      end

      S_POP_LD: begin
        if (ob_free) begin
          ob_ld               = 1'b1;
          ob_data.status      = ST_POPPED;
          ob_data.out_address = hdr_addr;
          ob_data.out_count   = 8'(hdr_cnt);
          ob_data.out_mode    = hdr_mode;
          ob_data.out_word    = (pop_k_r < hdr_fill) ? wrd_rdata : 16'd0;
          ob_data.out_last    = pop_last;
          ob_data.occupancy   = 5'(qcount_r);
          if (pop_last) begin
            state_nxt = S_IDLE;
          end else begin
            pop_k_nxt = pop_k_r + CW'(1);
            wrd_re    = 1'b1;
            wrd_raddr = word_addr(pop_slot_r, pop_k_r + CW'(1));
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      qcount_r  <= '0;
      run_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      qcount_r  <= qcount_nxt;
      run_idx_r <= run_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    run_st_r   <= run_st_nxt;
    run_addr_r <= run_addr_nxt;
    run_cnt_r  <= run_cnt_nxt;
    run_mode_r <= run_mode_nxt;
    scan_idx_r <= scan_idx_nxt;
    scan_n_r   <= scan_n_nxt;
    pop_slot_r <= pop_slot_nxt;
    pop_k_r    <= pop_k_nxt;
    res_st_r   <= res_st_nxt;
  end

  `CWQ_ASSERT_HOLDS(a_qcount_bound, qcount_r <= QCW'(QUEUE_DEPTH), "queue count above depth")
  `CWQ_ASSERT_HOLDS(a_run_idx_bound, run_idx_r <= CW'(MAX_WORDS), "push word index above limit")
  `CWQ_ASSERT_IMPL(a_scan_in_queue, state_r == S_MSCAN, scan_n_r < qcount_r, "merge scan past tail")
  `CWQ_ASSERT_NEXT(a_pop_dec, accept && in_data.opcode == OP_POP && qcount_r != '0, qcount_r == $past(qcount_r) - QCW'(1), "pop did not take an entry")

endmodule
